// ----- hw/rtl/assert_macros.svh -----
// Concurrent assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/bcse_pkg.sv -----
// Types, key codes and digit tables for the BCD clock set editor.
package bcse_pkg;

	localparam int CURSOR_W = 5;

	// key mask bit positions
	localparam int KB_EXE   = 0;
	localparam int KB_CLEAR = 1;
	localparam int KB_LEFT  = 2;
	localparam int KB_RIGHT = 3;
	localparam int KB_UP    = 4;
	localparam int KB_DOWN  = 5;
	localparam int KB_SAVE  = 6;

	localparam logic signed [CURSOR_W-1:0] CURSOR_IDLE = -5'sd1;
	localparam logic signed [CURSOR_W-1:0] CURSOR_FIRST = 5'sd0;
	localparam logic signed [CURSOR_W-1:0] CURSOR_LAST = 5'sd13;

	typedef struct packed {
		logic [7:0]  seconds;
		logic [7:0]  minutes;
		logic [7:0]  hours;
		logic [7:0]  day;
		logic [7:0]  month;
		logic [15:0] year;
	} time_set_t;

	localparam time_set_t HELD_RESET = '{
		seconds: 8'h00, minutes: 8'h01, hours: 8'h00,
		day: 8'h01, month: 8'h06, year: 16'h2021
	};

	typedef struct packed {
		logic [6:0]  key_mask;
		logic [7:0]  rtc_seconds;
		logic [7:0]  rtc_minutes;
		logic [7:0]  rtc_hours;
		logic [7:0]  rtc_day;
		logic [7:0]  rtc_month;
		logic [15:0] rtc_year;
	} scan_item_t;

	typedef struct packed {
		logic signed [CURSOR_W-1:0] cursor_pos;
		logic [7:0]  shown_seconds;
		logic [7:0]  shown_minutes;
		logic [7:0]  shown_hours;
		logic [7:0]  shown_day;
		logic [7:0]  shown_month;
		logic [15:0] shown_year;
		logic        commit_flag;
		logic        quit_flag;
	} result_item_t;

	// Largest legal digit at each cursor position.
	function automatic logic [3:0] pos_max(input logic [3:0] pos);
		logic [3:0] m;
		case (pos)
			4'd0:    m = 4'd2;
			4'd2:    m = 4'd5;
			4'd4:    m = 4'd5;
			4'd10:   m = 4'd1;
			4'd12:   m = 4'd3;
			default: m = 4'd9;
		endcase
		return m;
	endfunction

	// Wrapping step of one BCD digit; a result above the max becomes 0, down from 0 gives the max.
	function automatic logic [3:0] step_digit(input logic [3:0] d, input logic up,
	                                          input logic [3:0] dmax);
		logic [4:0] inc;
		logic [3:0] dec;
		logic [3:0] r;
		inc = {1'b0, d} + 5'd1;
		dec = (d == 4'd0) ? dmax : d - 4'd1;
		if (up) begin
			r = (inc > {1'b0, dmax}) ? 4'd0 : inc[3:0];
		end else begin
			r = (dec > dmax) ? 4'd0 : dec;
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/bcse_stream_if.sv -----
// Valid/ready stream channel with a typed payload.
interface bcse_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// ----- hw/rtl/bcd_clock_set_editor_core.sv -----
// BCD clock time/date set editor: cursor, held values and result register.
//
// Usage: each key scan arrives on the scan channel with a 7-bit key mask and
// the RTC's current BCD seconds, minutes, hours, day, month and year. Every
// scan yields exactly one item on the result channel: cursor position (-1
// idle, 0..13 digit), the six held BCD values, a commit flag (write the six
// values to the RTC) and a quit flag (exe or clear pressed).
// The result is registered: a scan transferred at a clock edge shows its result
// from the next cycle on. Throughput is one scan per cycle while the result
// channel does not stall; the editor state and the result register are the same
// flops, updated by one pass of logic (cursor move, digit select and BCD wrap).
// scan.ready is high while the result register is empty or being drained in
// the same cycle, so a stalled receiver holds the result and blocks new scans
// without losing anything.
// Reset puts the cursor idle, the held values to 00:01:00 01.06.2021 and
// empties the result register.
module bcd_clock_set_editor_core (
	input logic clk,
	input logic arst_n,
	bcse_stream_if.sink   scan,
	bcse_stream_if.source result
);
	import bcse_pkg::*;

	`include "assert_macros.svh"

	logic signed [CURSOR_W-1:0] cursor_q;
	time_set_t                  held_q;
	logic                       commit_q;
	logic                       quit_q;
	logic                       out_valid_q;

	scan_item_t                 s;
	logic                       take;
	time_set_t                  vals;
	logic signed [CURSOR_W-1:0] cur_nx;
	logic                       commit_nx;
	logic                       quit_nx;
	logic                       step_up;
	logic [3:0]                 dmax;

	assign s          = scan.payload;
	assign scan.ready = !out_valid_q || result.ready;
	assign take       = scan.valid && scan.ready;

	always_comb begin
		if (cursor_q == CURSOR_IDLE) begin
			vals = '{seconds: s.rtc_seconds, minutes: s.rtc_minutes,
			         hours: s.rtc_hours, day: s.rtc_day,
			         month: s.rtc_month, year: s.rtc_year};
		end else begin
			vals = held_q;
		end
		cur_nx    = cursor_q;
		commit_nx = 1'b0;
		quit_nx   = 1'b0;
		step_up   = !s.key_mask[KB_DOWN];
		dmax      = pos_max(cursor_q[3:0]);
		if (s.key_mask[KB_EXE] || s.key_mask[KB_CLEAR]) begin
			quit_nx = 1'b1;
		end else begin
			if (s.key_mask[KB_LEFT] && cur_nx > CURSOR_FIRST) begin
				cur_nx = cur_nx - 5'sd1;
			end
			if (s.key_mask[KB_RIGHT] && cur_nx < CURSOR_LAST) begin
				cur_nx = cur_nx + 5'sd1;
			end
			dmax = pos_max(cur_nx[3:0]);
			if ((s.key_mask[KB_UP] || s.key_mask[KB_DOWN]) && cur_nx >= CURSOR_FIRST) begin
				case (cur_nx[3:0])
					4'd0:  vals.hours[7:4]    = step_digit(vals.hours[7:4], step_up, dmax);
					4'd1:  vals.hours[3:0]    = step_digit(vals.hours[3:0], step_up, dmax);
					4'd2:  vals.minutes[7:4]  = step_digit(vals.minutes[7:4], step_up, dmax);
					4'd3:  vals.minutes[3:0]  = step_digit(vals.minutes[3:0], step_up, dmax);
					4'd4:  vals.seconds[7:4]  = step_digit(vals.seconds[7:4], step_up, dmax);
					4'd5:  vals.seconds[3:0]  = step_digit(vals.seconds[3:0], step_up, dmax);
					4'd6:  vals.year[15:12]   = step_digit(vals.year[15:12], step_up, dmax);
					4'd7:  vals.year[11:8]    = step_digit(vals.year[11:8], step_up, dmax);
					4'd8:  vals.year[7:4]     = step_digit(vals.year[7:4], step_up, dmax);
					4'd9:  vals.year[3:0]     = step_digit(vals.year[3:0], step_up, dmax);
					4'd10: vals.month[7:4]    = step_digit(vals.month[7:4], step_up, dmax);
					4'd11: vals.month[3:0]    = step_digit(vals.month[3:0], step_up, dmax);
					4'd12: vals.day[7:4]      = step_digit(vals.day[7:4], step_up, dmax);
					4'd13: vals.day[3:0]      = step_digit(vals.day[3:0], step_up, dmax);
					default: ;
				endcase
			end
			if (s.key_mask[KB_SAVE]) begin
				cur_nx    = CURSOR_IDLE;
				commit_nx = 1'b1;
			end
		end
	end

	// editor state doubles as the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q    <= CURSOR_IDLE;
			held_q      <= HELD_RESET;
			commit_q    <= 1'b0;
			quit_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				cursor_q    <= cur_nx;
				held_q      <= vals;
				commit_q    <= commit_nx;
				quit_q      <= quit_nx;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid   = out_valid_q;
	assign result.payload = '{
		cursor_pos: cursor_q,
		shown_seconds: held_q.seconds, shown_minutes: held_q.minutes,
		shown_hours: held_q.hours, shown_day: held_q.day,
		shown_month: held_q.month, shown_year: held_q.year,
		commit_flag: commit_q, quit_flag: quit_q
	};

	`ASSERT_IMP(a_commit_idle, clk, arst_n, out_valid_q && commit_q, cursor_q == CURSOR_IDLE && !quit_q)
	`ASSERT_NEXT(a_scan_result, clk, arst_n, take, out_valid_q)
	`ASSERT_IMP(a_cursor_range, clk, arst_n, 1'b1, cursor_q == CURSOR_IDLE || (cursor_q >= CURSOR_FIRST && cursor_q <= CURSOR_LAST))

endmodule

// ----- tb/sv/tb.sv -----
// Testbench for the BCD clock set editor core: directed and random key scans, scoreboard check.
module tb;
	import bcse_pkg::*;

	localparam logic [6:0] K_EXE   = 7'(1 << KB_EXE);
	localparam logic [6:0] K_CLEAR = 7'(1 << KB_CLEAR);
	localparam logic [6:0] K_LEFT  = 7'(1 << KB_LEFT);
	localparam logic [6:0] K_RIGHT = 7'(1 << KB_RIGHT);
	localparam logic [6:0] K_UP    = 7'(1 << KB_UP);
	localparam logic [6:0] K_DOWN  = 7'(1 << KB_DOWN);
	localparam logic [6:0] K_SAVE  = 7'(1 << KB_SAVE);
	localparam int         LAST_POS = 13;
	localparam int         N_RANDOM = 600;
	localparam int         STALL_LIMIT = 1000;

	typedef enum int {F_HOURS, F_MINUTES, F_SECONDS, F_YEAR, F_MONTH, F_DAY} field_t;

	class edit_scoreboard;
		int           cursor;
		time_set_t    held;
		result_item_t expected_q[$];
		int           errors;

		function new();
			cursor = -1;
			held = '{seconds: 8'h00, minutes: 8'h01, hours: 8'h00,
				day: 8'h01, month: 8'h06, year: 16'h2021};
			errors = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// which value, which nibble and the largest digit under each cursor position
		function void digit_at(input int pos, output field_t fld, output int nib,
		                       output int mx);
			case (pos)
				0:       begin fld = F_HOURS;   nib = 1; mx = 2; end
				1:       begin fld = F_HOURS;   nib = 0; mx = 9; end
				2:       begin fld = F_MINUTES; nib = 1; mx = 5; end
				3:       begin fld = F_MINUTES; nib = 0; mx = 9; end
				4:       begin fld = F_SECONDS; nib = 1; mx = 5; end
				5:       begin fld = F_SECONDS; nib = 0; mx = 9; end
				10:      begin fld = F_MONTH;   nib = 1; mx = 1; end
				11:      begin fld = F_MONTH;   nib = 0; mx = 9; end
				12:      begin fld = F_DAY;     nib = 1; mx = 3; end
				13:      begin fld = F_DAY;     nib = 0; mx = 9; end
				default: begin fld = F_YEAR;    nib = 9 - pos; mx = 9; end
			endcase
		endfunction

		function logic [15:0] bump(input logic [15:0] v, input int nib, input bit up,
		                           input int mx);
			int d;
			d = int'((v >> (nib * 4)) & 16'hf);
			if (up) begin
				d = (d + 1 > mx) ? 0 : d + 1;
			end else begin
				d = (d == 0) ? mx : d - 1;
				if (d > mx) d = 0;
			end
			v[nib*4 +: 4] = 4'(d);
			return v;
		endfunction

		function void note_scan(input scan_item_t it);
			result_item_t r;
			field_t       fld;
			int           nib;
			int           mx;
			bit           up;
			r = '0;
			if (cursor < 0) begin
				held.seconds = it.rtc_seconds;
				held.minutes = it.rtc_minutes;
				held.hours   = it.rtc_hours;
				held.day     = it.rtc_day;
				held.month   = it.rtc_month;
				held.year    = it.rtc_year;
			end
			if ((it.key_mask & (K_EXE | K_CLEAR)) != 0) begin
				r.quit_flag = 1'b1;
			end else begin
				if ((it.key_mask & K_LEFT) != 0 && cursor > 0) cursor--;
				if ((it.key_mask & K_RIGHT) != 0 && cursor < LAST_POS) cursor++;
				if ((it.key_mask & (K_UP | K_DOWN)) != 0 && cursor >= 0) begin
					up = (it.key_mask & K_DOWN) == 0;
					digit_at(cursor, fld, nib, mx);
					case (fld)
						F_HOURS:   held.hours   = 8'(bump(16'(held.hours), nib, up, mx));
						F_MINUTES: held.minutes = 8'(bump(16'(held.minutes), nib, up, mx));
						F_SECONDS: held.seconds = 8'(bump(16'(held.seconds), nib, up, mx));
						F_YEAR:    held.year    = bump(held.year, nib, up, mx);
						F_MONTH:   held.month   = 8'(bump(16'(held.month), nib, up, mx));
						default:   held.day     = 8'(bump(16'(held.day), nib, up, mx));
					endcase
				end
				if ((it.key_mask & K_SAVE) != 0) begin
					cursor = -1;
					r.commit_flag = 1'b1;
				end
			end
			r.cursor_pos    = 5'(cursor);
			r.shown_seconds = held.seconds;
			r.shown_minutes = held.minutes;
			r.shown_hours   = held.hours;
			r.shown_day     = held.day;
			r.shown_month   = held.month;
			r.shown_year    = held.year;
			expected_q.push_back(r);
		endfunction

		function void compare(input string what, input int want, input int got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, what,
					want, got);
			end
		endfunction

		function void check_result(input result_item_t got);
			result_item_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result transfer: expected none, actual %p",
					$time, got);
				return;
			end
			want = expected_q.pop_front();
			compare("cursor_pos", int'(want.cursor_pos), int'(got.cursor_pos));
			compare("shown_seconds", int'(want.shown_seconds), int'(got.shown_seconds));
			compare("shown_minutes", int'(want.shown_minutes), int'(got.shown_minutes));
			compare("shown_hours", int'(want.shown_hours), int'(got.shown_hours));
			compare("shown_day", int'(want.shown_day), int'(got.shown_day));
			compare("shown_month", int'(want.shown_month), int'(got.shown_month));
			compare("shown_year", int'(want.shown_year), int'(got.shown_year));
			compare("commit_flag", int'(want.commit_flag), int'(got.commit_flag));
			compare("quit_flag", int'(want.quit_flag), int'(got.quit_flag));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   steady_send;
	int   quiet_cycles = 0;

	edit_scoreboard board;

	bcse_stream_if #(.payload_t(scan_item_t))   scan_ch();
	bcse_stream_if #(.payload_t(result_item_t)) res_ch();

	bcd_clock_set_editor_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.scan(scan_ch),
		.result(res_ch)
	);

	always #5 clk = ~clk;

	task automatic send_scan(input scan_item_t it);
		while (!steady_send && $urandom_range(99) < 27) begin
			scan_ch.valid <= 1'b0;
			@(posedge clk);
		end
		scan_ch.valid <= 1'b1;
		scan_ch.payload <= it;
		do @(posedge clk); while (!scan_ch.ready);
		board.note_scan(it);
	endtask

	task automatic send_keys(input logic [6:0] keys, input time_set_t t);
		scan_item_t it;
		it.key_mask    = keys;
		it.rtc_seconds = t.seconds;
		it.rtc_minutes = t.minutes;
		it.rtc_hours   = t.hours;
		it.rtc_day     = t.day;
		it.rtc_month   = t.month;
		it.rtc_year    = t.year;
		send_scan(it);
	endtask

	// mostly edit-session keys; some noise masks and quits
	function automatic logic [6:0] pick_keys();
		int r;
		r = $urandom_range(99);
		if (r < 8) return 7'($urandom_range(127));
		if (r < 13) return ($urandom_range(1) != 0) ? K_EXE : K_CLEAR;
		if (r < 28) return K_LEFT;
		if (r < 46) return K_RIGHT;
		if (r < 64) return K_UP;
		if (r < 82) return K_DOWN;
		if (r < 85) return K_UP | K_DOWN;
		if (r < 92) return K_SAVE;
		if (r < 95) return '0;
		return 7'($urandom_range(63)) & (K_LEFT | K_RIGHT | K_UP | K_DOWN | K_SAVE);
	endfunction

	// receiver: random stalls, one long hold-off, one stall-free stretch
	initial begin
		int cyc;
		cyc = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc == 200) begin
				res_ch.ready <= 1'b0;
				repeat (40) @(posedge clk);
				cyc += 40;
				res_ch.ready <= 1'b1;
			end else if (cyc >= 500 && cyc < 650) begin
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= 27);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) board.check_result(res_ch.payload);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((scan_ch.valid && scan_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		time_set_t t_zero;
		time_set_t t_ones;
		time_set_t t_late;
		time_set_t t_rnd;
		t_zero = '0;
		t_ones = '1;
		t_late = '{seconds: 8'h59, minutes: 8'h59, hours: 8'h23,
			day: 8'h31, month: 8'h12, year: 16'h2099};
		arst_n = 1'b0;
		steady_send = 1'b0;
		scan_ch.valid = 1'b0;
		scan_ch.payload = '0;
		board = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: copy while idle, idle no-ops, cursor limits, wraps, quit and save
		send_keys('0, t_zero);
		send_keys(K_UP, t_late);
		send_keys(K_LEFT | K_DOWN, t_ones);
		send_keys(K_RIGHT, t_late);
		send_keys(K_LEFT, t_zero);
		send_keys(K_DOWN, t_zero);
		send_keys(K_UP | K_DOWN, t_zero);
		send_keys(K_DOWN, t_zero);
		for (int i = 0; i < LAST_POS; i++)
			send_keys(K_RIGHT | (i[0] ? K_UP : K_DOWN), t_zero);
		send_keys(K_RIGHT | K_UP, t_zero);
		send_keys('1, t_zero);
		send_keys(K_SAVE | K_LEFT | K_UP, t_zero);
		send_keys(K_CLEAR, t_ones);
		send_keys(K_EXE, t_late);
		send_keys(K_RIGHT, t_ones);
		send_keys(K_UP, t_zero);
		send_keys(K_RIGHT | K_DOWN, t_zero);
		send_keys(K_SAVE, t_zero);

		for (int n = 0; n < N_RANDOM; n++) begin
			steady_send = (n >= 250 && n < 350);
			if (n == 450) begin
				// let the block drain completely before going on
				scan_ch.valid <= 1'b0;
				do @(posedge clk); while (board.pending() != 0);
			end
			t_rnd = 56'({$urandom(), $urandom()});
			send_keys(pick_keys(), t_rnd);
		end
		scan_ch.valid <= 1'b0;

		while (board.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/bcse_pkg.sv
hw/rtl/bcse_stream_if.sv
hw/rtl/bcd_clock_set_editor_core.sv
tb/sv/tb.sv
